// File: rtl/sample_fifo_frame_pop_top_macros.svh
// assertion helpers for the sample fifo frame pop block
`ifndef SAMPLE_FIFO_FRAME_POP_TOP_MACROS_SVH
`define SAMPLE_FIFO_FRAME_POP_TOP_MACROS_SVH

// same-cycle implication, checked while out of reset
`define SFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfp check failed");

// next-cycle implication, checked while out of reset
`define SFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfp check failed");

`endif

// File: rtl/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types and constants of the sample fifo frame pop block
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int OP_W        = 2;
    localparam int CNT_W       = 11;
    localparam int SMP_W       = 16;
    localparam int FRAME_W     = 7;
    localparam int CTR_W       = 32;
    localparam int STATUS_W    = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 128;
    localparam int MAX_FRAME   = 64;
    localparam int Q_DEPTH     = 2;

    localparam logic [CNT_W-1:0]   CAP_RESET   = 11'd1024;
    localparam logic [FRAME_W-1:0] FRAME_RESET = 7'd64;

    // configuration register indexes
    localparam logic CFG_CAPACITY  = 1'b0;
    localparam logic CFG_FRAME_LEN = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_HDR = 2'd0,
        OP_PUSH_SMP = 2'd1,
        OP_POP      = 2'd2,
        OP_CLEAR    = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA     = 3'd0,
        ST_SILENCE  = 3'd1,
        ST_PUSH_OK  = 3'd2,
        ST_PUSH_REJ = 3'd3,
        ST_POP_BAD  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_POP  = 1'b1
    } t_state;

    // one result slot requested from the output queue
    typedef struct packed {
        logic    valid;
        logic    last;
        t_status status;
        logic    use_ram;
    } t_issue;

    // output queue status back to the controller
    typedef struct packed {
        logic can_issue;
        logic empty;
    } t_qstat;

endpackage

// File: rtl/sample_fifo_frame_pop_top.sv
// ----------------------------------------------------------------------------
// sample_fifo_frame_pop_top
// ring fifo of 16-bit audio samples with batch push and frame pop
//
// usage
//   slave stream takes one op item: push header, push sample, pop, clear
//   (op in tuser). push samples and clears give no result and are taken
//   one per cycle. a header or an invalid pop gives one result item,
//   a valid pop gives frame_len items with tlast on the final one
//   a result item passes through the in-flight slot register, then the result queue
//   throughput: one pop item per cycle while the master side is ready,
//   set by the single read port of the sample ram
//   the slave side stays closed until every result of the previous op
//   has been taken, so counters on the results are those after the op
//   master stall: a two-entry result queue holds items, and ram reads
//   pause until a slot frees up; nothing is dropped
//   reset (synchronous, active low): ring empty, counters zero,
//   capacity_in_use 1024, frame_len 64; sample ram is not cleared
//   configuration writes are taken at any edge with i_cfg_we high; the block has
//   no guard, so the user must make them only while the block is idle
// ----------------------------------------------------------------------------
module sample_fifo_frame_pop_top
    import sfp_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_idx,
    input  logic [CNT_W-1:0]       i_cfg_wdata,
    // op items
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // batch_count[10:0], sample_in[26:11]
    input  logic [OP_W-1:0]        i_s_axis_tuser,   // op[1:0]
    // result items
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // sample_out[15:0], fill_level[26:16],
                                                     // silence_frames[58:27],
                                                     // total_written[90:59],
                                                     // total_read[122:91]
    output logic                   o_m_axis_tlast,   // last
    output logic [STATUS_W-1:0]    o_m_axis_tuser    // status[2:0]
);

    localparam int AW = $clog2(STORE_DEPTH);

    t_issue           issue;
    t_qstat           qstat;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [SMP_W-1:0] wr_data;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [SMP_W-1:0] rd_data;
    logic [CNT_W-1:0] fill_level;
    logic [CTR_W-1:0] silence;
    logic [CTR_W-1:0] written;
    logic [CTR_W-1:0] total_rd;
    logic [SMP_W-1:0] q_sample;
    t_status          q_status;

    // decode, pointers, counters, frame sequencer
    sfp_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_s_axis_tvalid),
        .o_in_ready    (o_s_axis_tready),
        .i_op          (i_s_axis_tuser),
        .i_batch_count (i_s_axis_tdata[CNT_W-1:0]),
        .i_sample_in   (i_s_axis_tdata[CNT_W+SMP_W-1:CNT_W]),
        .i_qstat       (qstat),
        .o_issue       (issue),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .o_fill_level  (fill_level),
        .o_silence     (silence),
        .o_written     (written),
        .o_read        (total_rd)
    );

    // sample ring store
    sfp_ram #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // result queue toward the master side
    sfp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_ram_rdata (rd_data),
        .i_ready     (i_m_axis_tready),
        .o_qstat     (qstat),
        .o_valid     (o_m_axis_tvalid),
        .o_sample    (q_sample),
        .o_last      (o_m_axis_tlast),
        .o_status    (q_status)
    );

    // counters are stable while results drain, so they come straight from the controller
    assign o_m_axis_tdata = {5'b0, total_rd, written, silence, fill_level, q_sample};
    assign o_m_axis_tuser = q_status;

endmodule

// File: rtl/sfp_ram.sv
// ----------------------------------------------------------------------------
// sfp_ram
// sample ring store, one write and one registered read port
// ----------------------------------------------------------------------------
module sfp_ram
    import sfp_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [SMP_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [SMP_W-1:0] o_rd_data
);

    logic [SMP_W-1:0] r_mem [STORE_DEPTH];
    logic [SMP_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/sfp_outq.sv
// ----------------------------------------------------------------------------
// sfp_outq
// result stage: lines up issued slots with ram read data, two-entry queue
// ----------------------------------------------------------------------------
module sfp_outq
    import sfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_issue           i_issue,
    input  logic [SMP_W-1:0] i_ram_rdata,
    input  logic             i_ready,
    output t_qstat           o_qstat,
    output logic             o_valid,
    output logic [SMP_W-1:0] o_sample,
    output logic             o_last,
    output t_status          o_status
);

    localparam int QAW = $clog2(Q_DEPTH);
    localparam int OW  = $clog2(Q_DEPTH + 2);

    // slot in flight, waiting for the registered ram read data
    logic    r_pv;
    logic    r_plast;
    t_status r_pstatus;
    logic    r_puse;

    logic [SMP_W-1:0] r_q_sample [Q_DEPTH];
    logic             r_q_last   [Q_DEPTH];
    t_status          r_q_status [Q_DEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;

    logic          pop;
    logic [OW-1:0] occ;

    assign pop = o_valid && i_ready;
    // occupancy seen by the next slot, counting this cycle's pop
    assign occ = OW'(r_cnt) + OW'(r_pv) - OW'(pop);

    assign o_qstat.can_issue = (occ < OW'(Q_DEPTH));
    assign o_qstat.empty     = (r_cnt == '0) && !r_pv;

    assign o_valid  = (r_cnt != '0);
    assign o_sample = r_q_sample[r_rp];
    assign o_last   = r_q_last[r_rp];
    assign o_status = r_q_status[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_pv <= i_issue.valid;
            if (r_pv) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(r_pv) - (QAW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_plast   <= i_issue.last;
        r_pstatus <= i_issue.status;
        r_puse    <= i_issue.use_ram;
        if (r_pv) begin
            r_q_sample[r_wp] <= r_puse ? i_ram_rdata : '0;
            r_q_last[r_wp]   <= r_plast;
            r_q_status[r_wp] <= r_pstatus;
        end
    end

endmodule

// File: rtl/sfp_ctrl.sv
// ----------------------------------------------------------------------------
// sfp_ctrl
// op decode, ring pointers, counters and the frame read sequencer
// ----------------------------------------------------------------------------
module sfp_ctrl
    import sfp_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [CNT_W-1:0]   i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [OP_W-1:0]    i_op,
    input  logic [CNT_W-1:0]   i_batch_count,
    input  logic [SMP_W-1:0]   i_sample_in,
    input  t_qstat             i_qstat,
    output t_issue             o_issue,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [SMP_W-1:0]   o_wr_data,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_rd_addr,
    output logic [CNT_W-1:0]   o_fill_level,
    output logic [CTR_W-1:0]   o_silence,
    output logic [CTR_W-1:0]   o_written,
    output logic [CTR_W-1:0]   o_read
);

    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam int XW = ((CW > CNT_W) ? CW : CNT_W) + 1;

    function automatic logic [AW-1:0] f_adv(input logic [AW-1:0] p,
                                            input logic [XW-1:0] cap);
        logic [XW-1:0] nx;
        nx    = XW'(p) + XW'(1);
        f_adv = (nx >= cap) ? '0 : AW'(nx);
    endfunction

    t_state             r_state,     n_state;
    logic [CNT_W-1:0]   r_cap_cfg;
    logic [FRAME_W-1:0] r_frame_cfg;
    logic [AW-1:0]      r_wr_ptr,    n_wr_ptr;
    logic [AW-1:0]      r_rd_ptr,    n_rd_ptr;
    logic [CNT_W-1:0]   r_fill,      n_fill;
    logic [CNT_W-1:0]   r_batch_rem, n_batch_rem;
    logic [CTR_W-1:0]   r_silence,   n_silence;
    logic [CTR_W-1:0]   r_written,   n_written;
    logic [CTR_W-1:0]   r_read,      n_read;
    logic [FRAME_W-1:0] r_left,      n_left;
    logic               r_pop_data,  n_pop_data;

    logic [CNT_W-1:0] cap_raw;
    logic [XW-1:0]    eff_cap;
    logic [XW-1:0]    x_fill;
    logic [XW-1:0]    x_cnt;
    logic [XW-1:0]    x_n;
    logic             accept;
    logic             hdr_ok;
    logic             pop_bad;
    t_op              op;

    // effective capacity: zero counts as one, clipped to the store depth
    assign cap_raw = (r_cap_cfg == '0) ? CNT_W'(1) : r_cap_cfg;
    assign eff_cap = (XW'(cap_raw) > XW'(STORE_DEPTH)) ? XW'(STORE_DEPTH) : XW'(cap_raw);
    assign x_fill  = XW'(r_fill);
    assign x_cnt   = XW'(i_batch_count);
    assign x_n     = XW'(r_frame_cfg);

    assign hdr_ok  = (x_fill <= eff_cap) && (x_cnt <= eff_cap - x_fill);
    assign pop_bad = (r_frame_cfg == '0) || (x_n > eff_cap) || (x_n > XW'(MAX_FRAME));

    assign op         = t_op'(i_op);
    assign o_in_ready = (r_state == S_IDLE) && i_qstat.empty;
    assign accept     = i_in_valid && o_in_ready;

    assign o_wr_addr    = r_wr_ptr;
    assign o_wr_data    = i_sample_in;
    assign o_rd_addr    = r_rd_ptr;
    assign o_fill_level = r_fill;
    assign o_silence    = r_silence;
    assign o_written    = r_written;
    assign o_read       = r_read;

    always_comb begin
        n_state     = r_state;
        n_wr_ptr    = r_wr_ptr;
        n_rd_ptr    = r_rd_ptr;
        n_fill      = r_fill;
        n_batch_rem = r_batch_rem;
        n_silence   = r_silence;
        n_written   = r_written;
        n_read      = r_read;
        n_left      = r_left;
        n_pop_data  = r_pop_data;
        o_issue     = '0;
        o_wr_en     = 1'b0;
        o_rd_en     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (op)
                        OP_PUSH_HDR: begin
                            o_issue.valid = 1'b1;
                            o_issue.last  = 1'b1;
                            if (hdr_ok) begin
                                n_batch_rem    = i_batch_count;
                                o_issue.status = ST_PUSH_OK;
                            end else begin
                                n_batch_rem    = '0;
                                o_issue.status = ST_PUSH_REJ;
                            end
                        end
                        OP_PUSH_SMP: begin
                            if (r_batch_rem != '0) begin
                                if (x_fill >= eff_cap) begin
                                    // ring full after a capacity cut ends the batch
                                    n_batch_rem = '0;
                                end else begin
                                    o_wr_en     = 1'b1;
                                    n_wr_ptr    = f_adv(r_wr_ptr, eff_cap);
                                    n_fill      = r_fill + 1'b1;
                                    n_written   = r_written + 1'b1;
                                    n_batch_rem = r_batch_rem - 1'b1;
                                end
                            end
                        end
                        OP_POP: begin
                            if (pop_bad) begin
                                o_issue.valid  = 1'b1;
                                o_issue.last   = 1'b1;
                                o_issue.status = ST_POP_BAD;
                            end else if (x_fill < x_n) begin
                                if (r_silence != '1) begin
                                    n_silence = r_silence + 1'b1;
                                end
                                n_pop_data = 1'b0;
                                n_left     = r_frame_cfg;
                                n_state    = S_POP;
                            end else begin
                                n_fill     = r_fill - CNT_W'(r_frame_cfg);
                                n_read     = r_read + CTR_W'(r_frame_cfg);
                                n_pop_data = 1'b1;
                                n_left     = r_frame_cfg;
                                n_state    = S_POP;
                            end
                        end
                        OP_CLEAR: begin
                            n_wr_ptr    = '0;
                            n_rd_ptr    = '0;
                            n_fill      = '0;
                            n_batch_rem = '0;
                            n_silence   = '0;
                            n_written   = '0;
                            n_read      = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_POP: begin
                if (i_qstat.can_issue) begin
                    o_issue.valid   = 1'b1;
                    o_issue.last    = (r_left == FRAME_W'(1));
                    o_issue.status  = r_pop_data ? ST_DATA : ST_SILENCE;
                    o_issue.use_ram = r_pop_data;
                    if (r_pop_data) begin
                        o_rd_en  = 1'b1;
                        n_rd_ptr = f_adv(r_rd_ptr, eff_cap);
                    end
                    n_left = r_left - 1'b1;
                    if (r_left == FRAME_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap_cfg   <= CAP_RESET;
            r_frame_cfg <= FRAME_RESET;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_fill      <= '0;
            r_batch_rem <= '0;
            r_silence   <= '0;
            r_written   <= '0;
            r_read      <= '0;
            r_left      <= '0;
            r_pop_data  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_fill      <= n_fill;
            r_batch_rem <= n_batch_rem;
            r_silence   <= n_silence;
            r_written   <= n_written;
            r_read      <= n_read;
            r_left      <= n_left;
            r_pop_data  <= n_pop_data;
            if (i_cfg_we && (i_cfg_idx == CFG_CAPACITY)) begin
                r_cap_cfg <= i_cfg_wdata;
            end
            if (i_cfg_we && (i_cfg_idx == CFG_FRAME_LEN)) begin
                r_frame_cfg <= i_cfg_wdata[FRAME_W-1:0];
            end
        end
    end

endmodule

// File: rtl/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_checker
// port-level checks of the sample fifo frame pop block
// ----------------------------------------------------------------------------
`include "sample_fifo_frame_pop_top_macros.svh"

module sfp_checker
    import sfp_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_axis_tvalid,
    input logic                   o_s_axis_tready,
    input logic [OP_W-1:0]        i_s_axis_tuser,
    input logic                   o_m_axis_tvalid,
    input logic                   i_m_axis_tready,
    input logic                   o_m_axis_tlast,
    input logic [STATUS_W-1:0]    o_m_axis_tuser
);

    logic in_acc;
    assign in_acc = i_s_axis_tvalid && o_s_axis_tready;

    // a stalled result stays offered
    `SFP_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)

    // no op is taken while results of the previous one are pending
    `SFP_ASSERT_IMP(a_in_idle, i_clk, i_rst_n, o_s_axis_tready, !o_m_axis_tvalid)

    // a header answers with a single push status item
    `SFP_ASSERT_IMP(a_hdr_resp, i_clk, i_rst_n, in_acc && (i_s_axis_tuser == OP_PUSH_HDR), ##2 (o_m_axis_tvalid && o_m_axis_tlast && (o_m_axis_tuser == ST_PUSH_OK || o_m_axis_tuser == ST_PUSH_REJ)))

    // push samples and clears make no result
    `SFP_ASSERT_NXT(a_no_result, i_clk, i_rst_n, in_acc && (i_s_axis_tuser == OP_PUSH_SMP || i_s_axis_tuser == OP_CLEAR), !o_m_axis_tvalid)

    // single-item answers always close their run
    `SFP_ASSERT_IMP(a_single_last, i_clk, i_rst_n, o_m_axis_tvalid && (o_m_axis_tuser == ST_PUSH_OK || o_m_axis_tuser == ST_PUSH_REJ || o_m_axis_tuser == ST_POP_BAD), o_m_axis_tlast)

endmodule

bind sample_fifo_frame_pop_top sfp_checker u_sfp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tlast  (o_m_axis_tlast),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

// File: bench/tb_sample_fifo_frame_pop_top.sv
// ----------------------------------------------------------------------------
// tb_sample_fifo_frame_pop_top
// self-checking bench for the audio sample ring fifo with batch push and
// frame pop: a directed opening on the corner cases, then randomized phases
// at several capacity and frame settings. every item taken on the slave side
// goes through a ring predictor, and every item on the master side is
// compared field by field with the oldest predicted item
// ----------------------------------------------------------------------------
module tb_sample_fifo_frame_pop_top
    import sfp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 8;     // lets a last sample push or clear settle, with margin
    localparam int QUIET_LIMIT   = 2000;  // cycles with no item moving on either side

    // one predicted result item, counters as they stand after the whole op
    typedef struct {
        logic [SMP_W-1:0] smp;
        logic             last;
        t_status          status;
        logic [CNT_W-1:0] fill;
        logic [CTR_W-1:0] silence;
        logic [CTR_W-1:0] written;
        logic [CTR_W-1:0] popped;
    } t_frame_item;

    // ring predictor plus the queue of result items still owed by the block
    class audio_ring_sb;
        logic [SMP_W-1:0] ring [RING_DEPTH];
        int unsigned      wr_ptr, rd_ptr, fill, batch_left;
        logic [CTR_W-1:0] n_silence, n_written, n_read;
        int unsigned      cap_reg, frame_len;
        t_frame_item      frame_items_due [$];
        int unsigned      errors;

        function new();
            foreach (ring[i]) ring[i] = '0;
            clear_state();
            cap_reg   = CAP_RESET;
            frame_len = FRAME_RESET;
            errors    = 0;
        endfunction

        function void clear_state();
            wr_ptr     = 0;
            rd_ptr     = 0;
            fill       = 0;
            batch_left = 0;
            n_silence  = '0;
            n_written  = '0;
            n_read     = '0;
        endfunction

        function void write_reg(logic idx, logic [CNT_W-1:0] val);
            if (idx == CFG_CAPACITY) begin
                cap_reg = val;
            end else begin
                frame_len = val[FRAME_W-1:0];
            end
        endfunction

        // zero acts as one slot, anything past the store saturates
        function int unsigned ring_cap();
            if (cap_reg == 0) return 1;
            if (cap_reg > RING_DEPTH) return RING_DEPTH;
            return cap_reg;
        endfunction

        function int unsigned step_ptr(int unsigned p, int unsigned cap);
            return (p + 1 >= cap) ? 0 : p + 1;
        endfunction

        function int unsigned pending();
            return frame_items_due.size();
        endfunction

        function void owe_item(logic [SMP_W-1:0] smp, logic last, t_status status);
            t_frame_item it;
            it.smp     = smp;
            it.last    = last;
            it.status  = status;
            it.fill    = CNT_W'(fill);
            it.silence = n_silence;
            it.written = n_written;
            it.popped  = n_read;
            frame_items_due.push_back(it);
        endfunction

        // called for every item taken on the slave side
        function void take_op(t_op op, logic [CNT_W-1:0] cnt, logic [SMP_W-1:0] smp);
            int unsigned      cap, n;
            logic [SMP_W-1:0] vals [$];
            cap = ring_cap();
            case (op)
                OP_PUSH_HDR: begin
                    // the whole batch has to fit, a header also drops any open batch
                    if (fill <= cap && cnt <= cap - fill) begin
                        batch_left = cnt;
                        owe_item('0, 1'b1, ST_PUSH_OK);
                    end else begin
                        batch_left = 0;
                        owe_item('0, 1'b1, ST_PUSH_REJ);
                    end
                end
                OP_PUSH_SMP: begin
                    if (batch_left != 0) begin
                        if (fill >= cap) begin
                            batch_left = 0;
                        end else begin
                            ring[wr_ptr] = smp;
                            wr_ptr       = step_ptr(wr_ptr, cap);
                            fill++;
                            n_written++;
                            batch_left--;
                        end
                    end
                end
                OP_POP: begin
                    n = frame_len;
                    if (n == 0 || n > cap || n > MAX_FRAME) begin
                        owe_item('0, 1'b1, ST_POP_BAD);
                    end else if (fill < n) begin
                        if (n_silence != '1) n_silence++;
                        for (int i = 0; i < n; i++) owe_item('0, i == n - 1, ST_SILENCE);
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            vals.push_back(ring[rd_ptr]);
                            rd_ptr = step_ptr(rd_ptr, cap);
                        end
                        fill   -= n;
                        n_read += n;
                        for (int i = 0; i < n; i++) owe_item(vals[i], i == n - 1, ST_DATA);
                    end
                end
                default: begin
                    clear_state();
                end
            endcase
        endfunction

        function void compare(string field, logic [CTR_W-1:0] want, logic [CTR_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // called for every item taken on the master side
        function void check_frame_item(t_frame_item got);
            t_frame_item want;
            if (frame_items_due.size() == 0) begin
                errors++;
                $display("%0t: result item with none expected, expected none, actual %0h",
                         $time, got.smp);
                return;
            end
            want = frame_items_due.pop_front();
            compare("sample_out", CTR_W'(want.smp), CTR_W'(got.smp));
            compare("last", CTR_W'(want.last), CTR_W'(got.last));
            compare("status", CTR_W'(want.status), CTR_W'(got.status));
            compare("fill_level", CTR_W'(want.fill), CTR_W'(got.fill));
            compare("silence_frames", want.silence, got.silence);
            compare("total_written", want.written, got.written);
            compare("total_read", want.popped, got.popped);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic                   i_cfg_idx;
    logic [CNT_W-1:0]       i_cfg_wdata;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic [OP_W-1:0]        i_s_axis_tuser;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   o_m_axis_tlast;
    logic [STATUS_W-1:0]    o_m_axis_tuser;

    audio_ring_sb sb;
    bit           steady = 1'b0;    // phase without idling on either side
    int unsigned  stall_left = 0;   // receiver stall still to run
    int unsigned  ops_sent = 0;
    int unsigned  quiet_cycles = 0;

    sample_fifo_frame_pop_top #(
        .STORE_DEPTH(RING_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #6 i_clk = ~i_clk;

    // idle length for either side: mostly none, often a few, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls on the master side, none in steady phases
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left      <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left      <= idle_len();
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // result monitor and watchdog on stalled traffic
    always @(posedge i_clk) begin
        t_frame_item seen;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            // tdata: sample_out, fill_level, silence_frames, total_written, total_read
            seen.smp     = o_m_axis_tdata[15:0];
            seen.fill    = o_m_axis_tdata[26:16];
            seen.silence = o_m_axis_tdata[58:27];
            seen.written = o_m_axis_tdata[90:59];
            seen.popped  = o_m_axis_tdata[122:91];
            seen.last    = o_m_axis_tlast;
            seen.status  = t_status'(o_m_axis_tuser);
            sb.check_frame_item(seen);
        end
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_sample_fifo_frame_pop_top: errors");
            $finish;
        end
    end

    // one op item on the slave side, after a random idle stretch
    task automatic send_op(input t_op op, input logic [CNT_W-1:0] cnt,
                           input logic [SMP_W-1:0] smp);
        int unsigned gap;
        gap = idle_len();
        repeat (gap) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        // tdata: batch_count in the low bits, sample_in above it
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_TDATA_W'({smp, cnt});
        i_s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.take_op(op, cnt, smp);
        ops_sent++;
    endtask

    // sender stops until every owed result item is in, then lets the
    // block finish any sample push or clear that gives no result
    task automatic hold_until_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // both registers, back to back; only called while the block is idle
    task automatic configure(input int unsigned cap, input int unsigned frame);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_CAPACITY;
        i_cfg_wdata <= CNT_W'(cap);
        @(posedge i_clk);
        sb.write_reg(CFG_CAPACITY, CNT_W'(cap));
        i_cfg_idx   <= CFG_FRAME_LEN;
        i_cfg_wdata <= CNT_W'(frame);
        @(posedge i_clk);
        sb.write_reg(CFG_FRAME_LEN, CNT_W'(frame));
        i_cfg_we    <= 1'b0;
    endtask

    // clear, reprogram, then mostly well-formed batches and pops with noise mixed in;
    // the clear first keeps both pointers at zero so a pop never reaches a slot
    // that was never written
    task automatic random_phase(input int unsigned cap, input int unsigned frame,
                                input int unsigned quota);
        int unsigned stop_at, room, n, k, pick;
        send_op(OP_CLEAR, CNT_W'($urandom), SMP_W'($urandom));
        hold_until_drained();
        configure(cap, frame);
        steady  = ($urandom_range(0, 3) == 0);
        stop_at = ops_sent + quota;
        while (ops_sent < stop_at) begin
            room = sb.ring_cap() - sb.fill;
            pick = $urandom_range(0, 99);
            if (pick >= 50 && pick < 80 && (sb.fill >= sb.frame_len || $urandom_range(0, 3) == 0)) begin
                send_op(OP_POP, CNT_W'($urandom), SMP_W'($urandom));
            end else if (pick < 80) begin
                // header that fits, then its samples; now and then the ring is
                // filled to the brim or the batch is cut short
                n = $urandom_range(0, (room < 24) ? room : 24);
                if (room <= 64 && $urandom_range(0, 9) == 0) n = room;
                k = n;
                if ($urandom_range(0, 9) == 0) k = $urandom_range(0, n);
                send_op(OP_PUSH_HDR, CNT_W'(n), SMP_W'($urandom));
                repeat (k) send_op(OP_PUSH_SMP, CNT_W'($urandom), SMP_W'($urandom));
            end else if (pick < 87) begin
                // header that cannot fit
                send_op(OP_PUSH_HDR, CNT_W'($urandom_range(room + 1, 2047)), SMP_W'($urandom));
            end else if (pick < 94) begin
                // stray sample, stored only if a cut-short batch is still open
                send_op(OP_PUSH_SMP, CNT_W'($urandom), SMP_W'($urandom));
            end else if (pick < 97) begin
                send_op(OP_CLEAR, CNT_W'($urandom), SMP_W'($urandom));
            end else begin
                hold_until_drained();
            end
        end
    endtask

    initial begin
        sb = new();
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_CAPACITY;
        i_cfg_wdata     <= '0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= OP_PUSH_HDR;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: capacity 1024, frame 64
        send_op(OP_POP, 11'd0, 16'h0000);           // empty ring, a full 64-item silent frame
        send_op(OP_PUSH_HDR, 11'd2047, 16'hffff);   // widest count, never fits
        send_op(OP_PUSH_HDR, 11'd1024, 16'h0000);   // exactly the whole ring
        send_op(OP_PUSH_HDR, 11'd0, 16'h8000);      // empty batch, drops the open one
        send_op(OP_PUSH_SMP, 11'h7ff, 16'h1234);    // no batch open, dropped
        send_op(OP_POP, 11'h7ff, 16'hffff);         // second silent frame
        hold_until_drained();

        configure(1024, 4);
        send_op(OP_PUSH_HDR, 11'd4, 16'h0000);
        send_op(OP_PUSH_SMP, 11'd0, 16'h7fff);      // sample extremes
        send_op(OP_PUSH_SMP, 11'd0, 16'h8000);
        send_op(OP_PUSH_SMP, 11'd0, 16'h0000);
        send_op(OP_PUSH_SMP, 11'd0, 16'hffff);
        send_op(OP_PUSH_SMP, 11'd0, 16'h5a5a);      // past the batch, dropped
        send_op(OP_POP, 11'd0, 16'h0000);           // data frame
        send_op(OP_PUSH_HDR, 11'd3, 16'h0000);
        send_op(OP_PUSH_SMP, 11'd0, 16'h0064);
        send_op(OP_PUSH_HDR, 11'd1, 16'h0000);      // header inside an open batch
        send_op(OP_PUSH_SMP, 11'd0, 16'h0007);
        send_op(OP_PUSH_SMP, 11'd0, 16'h0008);      // dropped
        send_op(OP_POP, 11'd0, 16'h0000);           // two buffered, frame of four: silence
        send_op(OP_CLEAR, 11'd0, 16'h0000);
        hold_until_drained();

        // capacity lowered under an open batch: the next sample finds the ring full
        configure(8, 4);
        send_op(OP_PUSH_HDR, 11'd6, 16'h0000);
        repeat (4) send_op(OP_PUSH_SMP, CNT_W'($urandom), SMP_W'($urandom));
        hold_until_drained();
        configure(4, 4);
        send_op(OP_PUSH_SMP, 11'd0, 16'h4321);      // ring full, batch ends
        send_op(OP_PUSH_SMP, 11'd0, 16'h1111);      // dropped
        send_op(OP_POP, 11'd0, 16'h0000);           // read pointer wraps at the new capacity
        hold_until_drained();
        configure(4, 8);
        send_op(OP_POP, 11'd0, 16'h0000);           // frame longer than capacity

        // randomized phases, extremes included
        random_phase(1, 1, 50);
        random_phase(2, 2, 50);
        random_phase(5, 4, 50);
        random_phase(13, 8, 50);
        random_phase(64, 64, 50);
        random_phase(100, 16, 50);
        random_phase(1024, 64, 50);
        random_phase(1024, 1, 50);
        random_phase($urandom_range(1, 1024), $urandom_range(1, 64), 50);
        hold_until_drained();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_sample_fifo_frame_pop_top: clean");
        end else begin
            $display("tb_sample_fifo_frame_pop_top: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sfp_pkg.sv
rtl/sfp_ram.sv
rtl/sfp_outq.sv
rtl/sfp_ctrl.sv
rtl/sample_fifo_frame_pop_top.sv
rtl/sfp_checker.sv
bench/tb_sample_fifo_frame_pop_top.sv
